FILE: src/psu_pkg.sv
// shared types and constants for the png scanline unfilter
`default_nettype none

package psu_pkg;

    localparam int MAX_LINE_BYTES  = 4096;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int POS_W   = $clog2(MAX_LINE_BYTES);
    localparam int LEN_W   = 13;
    localparam int BPP_W   = 4;
    localparam int SLOT_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES  = 1'd1;

    localparam logic [BPP_W-1:0] PIXEL_BYTES_RESET = 4'd4;
    localparam logic [LEN_W-1:0] LINE_BYTES_RESET  = 13'd4096;

    typedef enum logic [2:0] {
        FLT_NONE    = 3'd0,
        FLT_SUB     = 3'd1,
        FLT_UP      = 3'd2,
        FLT_AVG     = 3'd3,
        FLT_PAETH   = 3'd4,
        FLT_UNKNOWN = 3'd5
    } filter_kind_t;

    // one data byte on its way from the front end to reconstruction
    typedef struct packed {
        logic               valid;
        logic [POS_W-1:0]   pos;
        logic [SLOT_W-1:0]  slot;
        logic               left_ok;
        logic               first_row;
        logic               last;
        filter_kind_t       kind;
        logic [BYTE_W-1:0]  data;
    } psu_item_t;

endpackage

`default_nettype wire

FILE: src/psu_line_store.sv
// prior-row line store, one write and one registered read port
`default_nettype none

module psu_line_store
    import psu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [POS_W-1:0]  rd_addr,
    output logic      [BYTE_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [POS_W-1:0]  wr_addr,
    input  wire logic [BYTE_W-1:0] wr_data
);

    logic [BYTE_W-1:0] mem [MAX_LINE_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/psu_ctrl.sv
// front end: config registers, line position tracking, first pipeline stage
`default_nettype none

module psu_ctrl
    import psu_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  take,
    output psu_item_t                  item,
    output logic                       rd_en,
    output logic      [POS_W-1:0]      rd_addr
);

    logic [BPP_W-1:0]  pixel_bytes_reg;
    logic [LEN_W-1:0]  line_bytes_reg;
    logic [BPP_W-1:0]  bpp_eff;
    logic [LEN_W-1:0]  len_eff;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SLOT_W-1:0] mod_cnt_reg [MAX_PIXEL_BYTES];
    logic [SLOT_W-1:0] mod_cnt_next [MAX_PIXEL_BYTES];
    filter_kind_t      kind_reg, kind_next;
    logic              first_row_reg, first_row_next;
    logic              await_reg, await_next;
    psu_item_t         item_reg, item_next;

    logic              acc;
    logic              type_byte;
    logic              row_one;
    logic              line_done;
    logic [SLOT_W-1:0] slot_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_bytes_reg <= PIXEL_BYTES_RESET;
            line_bytes_reg  <= LINE_BYTES_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PIXEL_BYTES: pixel_bytes_reg <= cfg_data[BPP_W-1:0];
                CFG_LINE_BYTES:  line_bytes_reg  <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // out-of-range settings clamp into the legal range
    always_comb begin
        if (pixel_bytes_reg == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (pixel_bytes_reg > BPP_W'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = pixel_bytes_reg;
        end
        if (line_bytes_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (line_bytes_reg > LEN_W'(MAX_LINE_BYTES)) begin
            len_eff = LEN_W'(MAX_LINE_BYTES);
        end else begin
            len_eff = line_bytes_reg;
        end
    end

    assign s_tready  = !item_reg.valid || take;
    assign acc       = s_tvalid && s_tready;
    assign type_byte = s_tuser || await_reg;
    assign row_one   = s_tuser || first_row_reg;
    assign line_done = ({1'b0, pos_reg} + LEN_W'(1)) >= len_eff;
    // column mod k kept by one wrapping counter per pixel size
    assign slot_sel  = mod_cnt_reg[SLOT_W'(bpp_eff - BPP_W'(1))];

    always_comb begin
        pos_next       = pos_reg;
        mod_cnt_next   = mod_cnt_reg;
        kind_next      = kind_reg;
        first_row_next = first_row_reg;
        await_next     = await_reg;
        item_next      = item_reg;
        if (take) begin
            item_next.valid = 1'b0;
        end
        if (acc) begin
            if (type_byte) begin
                kind_next      = (s_tdata > BYTE_W'(FLT_PAETH)) ? FLT_UNKNOWN
                                                                : filter_kind_t'(s_tdata[2:0]);
                await_next     = 1'b0;
                pos_next       = '0;
                first_row_next = row_one;
                for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                    mod_cnt_next[k] = '0;
                end
            end else begin
                item_next.valid     = 1'b1;
                item_next.pos       = pos_reg;
                item_next.slot      = slot_sel;
                item_next.left_ok   = {1'b0, pos_reg} >= LEN_W'(bpp_eff);
                item_next.first_row = first_row_reg;
                item_next.last      = line_done;
                item_next.kind      = kind_reg;
                item_next.data      = s_tdata;
                if (line_done) begin
                    pos_next       = '0;
                    first_row_next = 1'b0;
                    await_next     = 1'b1;
                    for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                        mod_cnt_next[k] = '0;
                    end
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                    for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                        mod_cnt_next[k] = (mod_cnt_reg[k] == SLOT_W'(k)) ? '0
                                          : mod_cnt_reg[k] + SLOT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            kind_reg       <= FLT_NONE;
            first_row_reg  <= 1'b1;
            await_reg      <= 1'b1;
            item_reg.valid <= 1'b0;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                mod_cnt_reg[k] <= '0;
            end
        end else begin
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            first_row_reg <= first_row_next;
            await_reg     <= await_next;
            item_reg      <= item_next;
            mod_cnt_reg   <= mod_cnt_next;
        end
    end

    assign item    = item_reg;
    assign rd_en   = acc && !type_byte;
    assign rd_addr = pos_reg;

endmodule

`default_nettype wire

FILE: src/psu_recon.sv
// predictor, byte histories, line store write-back and output register
`default_nettype none

module psu_recon
    import psu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire psu_item_t         item,
    input  wire logic [BYTE_W-1:0] above_raw,
    output logic                   take,
    output logic                   wr_en,
    output logic      [POS_W-1:0]  wr_addr,
    output logic      [BYTE_W-1:0] wr_data,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [BYTE_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    logic [BYTE_W-1:0] left_hist_reg [MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0] abl_hist_reg  [MAX_PIXEL_BYTES];

    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_data_reg;
    logic              m_last_reg;
    logic              m_bad_reg;

    logic [BYTE_W-1:0] left, above, above_left;
    logic [BYTE_W:0]   avg_sum;
    logic signed [9:0] d_bc, d_ac, d_abc;
    logic [9:0]        pa, pb, pc;
    logic [BYTE_W-1:0] paeth;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] result;

    assign take = item.valid && (!m_valid_reg || m_tready);

    always_comb begin
        left       = item.left_ok ? left_hist_reg[item.slot] : '0;
        above      = item.first_row ? '0 : above_raw;
        above_left = (!item.first_row && item.left_ok) ? abl_hist_reg[item.slot] : '0;
    end

    // paeth distances, all on 10-bit signed values
    always_comb begin
        d_bc  = $signed({2'b00, above}) - $signed({2'b00, above_left});
        d_ac  = $signed({2'b00, left})  - $signed({2'b00, above_left});
        d_abc = $signed({2'b00, left}) + $signed({2'b00, above})
                - $signed({1'b0, above_left, 1'b0});
        pa = (d_bc  < 0) ? 10'(-d_bc)  : 10'(d_bc);
        pb = (d_ac  < 0) ? 10'(-d_ac)  : 10'(d_ac);
        pc = (d_abc < 0) ? 10'(-d_abc) : 10'(d_abc);
        if (pa <= pb && pa <= pc) begin
            paeth = left;
        end else if (pb <= pc) begin
            paeth = above;
        end else begin
            paeth = above_left;
        end
    end

    assign avg_sum = {1'b0, left} + {1'b0, above};

    always_comb begin
        case (item.kind) inside
            FLT_SUB:               pred = left;
            FLT_UP:                pred = above;
            FLT_AVG:               pred = avg_sum[BYTE_W:1];
            FLT_PAETH:             pred = paeth;
            FLT_NONE, FLT_UNKNOWN: pred = '0;
            default:               pred = '0;
        endcase
    end

    assign result  = item.data + pred;
    assign wr_en   = take;
    assign wr_addr = item.pos;
    assign wr_data = result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                left_hist_reg[k] <= '0;
                abl_hist_reg[k]  <= '0;
            end
        end else if (take) begin
            left_hist_reg[item.slot] <= result;
            abl_hist_reg[item.slot]  <= above;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= result;
            m_last_reg <= item.last;
            m_bad_reg  <= (item.kind == FLT_UNKNOWN);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_bad_reg;

endmodule

`default_nettype wire

FILE: src/png_scanline_unfilter.sv
// top level of the png scanline unfilter
//
// takes the inflated, still filtered png byte stream on the s_ channel, one
// byte per request, and returns reconstructed image bytes on the m_ channel
// - s_tdata carries the stream byte; s_tuser marks the first byte of an image,
//   which is always the filter type byte of the first row
// - the first byte of every scanline is its filter type and yields no result;
//   every later byte yields exactly one result, m_tlast on the last of a line
//   and m_tuser on every byte of a line whose filter type was above four
// - pixel size and line length are set through the cfg_ write port while the
//   block is idle; they apply from the next byte on
// - throughput: one byte per clock, type bytes included, unless the output
//   stalls; the prior-row read goes out as a byte is taken, with any
//   write-back of the byte before it, and the two never address the same
//   entry; a data byte passes the front stage, then the output register
// - when the receiver stalls, the output register holds its result and one
//   more byte waits in the front stage; s_tready then falls until the
//   output register is taken
// - reset clears position, histories and flags and restores both register
//   defaults; the line store keeps its contents, the first row ignores it
`default_nettype none

module png_scanline_unfilter
    import psu_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // filtered_byte
    input  wire logic                  s_tuser,   // image_start
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [7:0]            m_tdata,   // pixel_byte
    output logic                       m_tlast,   // line_end
    output logic                       m_tuser    // bad_filter
);

    psu_item_t         item;
    logic              take;
    logic              rd_en;
    logic [POS_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              wr_en;
    logic [POS_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;

    // front stage: position, filter type and line store read
    psu_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .take      (take),
        .item      (item),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    // bytes of the row above, written back as each byte is rebuilt
    psu_line_store u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // predictor and output register
    psu_recon u_recon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .above_raw (rd_data),
        .take      (take),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: src/psu_checker.sv
// port-level checks for the png scanline unfilter, bound to the top level
`default_nettype none

module psu_checker (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [7:0]            m_tdata,
    input wire logic                  m_tlast,
    input wire logic                  m_tuser
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result changed");

    // no result appears without a byte taken into the front stage before it
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_acc ##1 (!s_acc && !m_tvalid) |=> !m_tvalid)
        else $error("result without input");

    // an empty output never holds back the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);

`default_nettype wire
